FILE: hw/rtl/dpbp_pkg.sv
// shared types and constants for the depth pixel back-projection block
package dpbp_pkg;

  localparam int unsigned DepthW  = 15;
  localparam int unsigned OffW    = 18;
  localparam int unsigned FocalW  = 24;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_MIN_DEPTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DEPTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_COL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_ROW = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INV_FOCAL  = 3'd4;

  localparam logic [14:0] MIN_DEPTH_RST  = 15'd39;
  localparam logic [14:0] MAX_DEPTH_RST  = 15'd1280;
  localparam logic [16:0] CENTER_COL_RST = 17'd39450;
  localparam logic [15:0] CENTER_ROW_RST = 16'd30398;
  localparam logic [23:0] INV_FOCAL_RST  = 24'd66660;

  typedef struct packed {
    logic signed [15:0] depth_raw;
    logic        [7:0]  pixel_row;
    logic        [8:0]  pixel_col;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic        [14:0] point_z;
    logic               clipped;
  } out_word_t;

  typedef struct packed {
    logic [14:0] min_depth;
    logic [14:0] max_depth;
    logic [16:0] center_col;
    logic [15:0] center_row;
    logic [23:0] inv_focal;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    logic signed [OffW-1:0] off_x;
    logic signed [OffW-1:0] off_y;
    logic [DepthW-1:0]      z;
  } front_t;

endpackage

FILE: hw/rtl/dpbp_front.sv
// first stage: frame and depth range check, principal point offsets
module dpbp_front import dpbp_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 320,
  parameter int unsigned FRAME_HEIGHT = 240
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t word_i,
  input  cfg_t     cfg_i,
  output front_t   front_o
);

  logic                   keep;
  logic                   valid_q;
  logic signed [OffW-1:0] off_x_d, off_y_d, off_x_q, off_y_q;
  logic [DepthW-1:0]      z_q;

  always_comb begin
    keep = ({5'b0, word_i.pixel_row} < 13'(FRAME_HEIGHT))
        && ({4'b0, word_i.pixel_col} < 13'(FRAME_WIDTH))
        && (word_i.depth_raw >= $signed({1'b0, cfg_i.min_depth}))
        && (word_i.depth_raw <= $signed({1'b0, cfg_i.max_depth}));
    off_x_d = $signed({1'b0, word_i.pixel_col, 8'b0}) - $signed({1'b0, cfg_i.center_col});
    off_y_d = $signed({2'b0, word_i.pixel_row, 8'b0}) - $signed({2'b0, cfg_i.center_row});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    off_x_q <= off_x_d;
    off_y_q <= off_y_d;
    z_q     <= word_i.depth_raw[DepthW-1:0];
  end

  assign front_o = '{valid: valid_q, off_x: off_x_q, off_y: off_y_q, z: z_q};

endmodule

FILE: hw/rtl/dpbp_lane.sv
// one coordinate lane: offset times depth times inverse focal, shift and saturate
module dpbp_lane import dpbp_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [OffW-1:0] off_i,
  input  logic [DepthW-1:0]      z_i,
  input  logic [FocalW-1:0]      inv_focal_i,
  output logic signed [15:0]     coord_o,
  output logic                   sat_o
);

  logic signed [33:0] prod_q;
  logic signed [46:0] lo_q, hi_q;
  logic signed [58:0] sum;
  logic               ovf;
  logic signed [15:0] coord_d, coord_q;
  logic               sat_q;

  always_ff @(posedge clk_i) begin
    prod_q <= off_i * $signed({1'b0, z_i});
  end

  // split the focal factor in halves to keep each multiplier narrow
  always_ff @(posedge clk_i) begin
    lo_q <= prod_q * $signed({1'b0, inv_focal_i[11:0]});
    hi_q <= prod_q * $signed({1'b0, inv_focal_i[23:12]});
  end

  always_comb begin
    sum = $signed({hi_q, 12'b0}) + $signed({{12{lo_q[46]}}, lo_q});
    ovf = (sum[58:47] != {12{sum[47]}});
    if (ovf) begin
      coord_d = sum[58] ? 16'sh8000 : 16'sh7fff;
    end else begin
      coord_d = sum[47:32];
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    sat_q   <= ovf;
  end

  assign coord_o = coord_q;
  assign sat_o   = sat_q;

endmodule

FILE: hw/rtl/depth_pixel_backprojection.sv
// top level: config registers, front stage, x and y lanes, output word
// a kept word passes the front register and then the v2, v3 and v4 valid registers before it shows on out_valid_o
// throughput: one word per cycle, busy is never raised
// results are strobed for one cycle; the receiver cannot stall
// reset clears config to defaults and empties the valid pipeline
module depth_pixel_backprojection import dpbp_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 320,
  parameter int unsigned FRAME_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output logic               out_valid_o,
  output out_word_t          result_o
);

  cfg_t              cfg_q;
  front_t            front;
  logic              v2_q, v3_q, v4_q;
  logic [DepthW-1:0] z2_q, z3_q, z4_q;
  logic signed [15:0] x_coord, y_coord;
  logic              x_sat, y_sat;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_depth  <= MIN_DEPTH_RST;
      cfg_q.max_depth  <= MAX_DEPTH_RST;
      cfg_q.center_col <= CENTER_COL_RST;
      cfg_q.center_row <= CENTER_ROW_RST;
      cfg_q.inv_focal  <= INV_FOCAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DEPTH:  cfg_q.min_depth  <= cfg_wdata_i[14:0];
        CFG_MAX_DEPTH:  cfg_q.max_depth  <= cfg_wdata_i[14:0];
        CFG_CENTER_COL: cfg_q.center_col <= cfg_wdata_i[16:0];
        CFG_CENTER_ROW: cfg_q.center_row <= cfg_wdata_i[15:0];
        CFG_INV_FOCAL:  cfg_q.inv_focal  <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  dpbp_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(start && !busy),
    .word_i  (in_i),
    .cfg_i   (cfg_q),
    .front_o (front)
  );

  dpbp_lane u_lane_x (
    .clk_i      (clk_i),
    .off_i      (front.off_x),
    .z_i        (front.z),
    .inv_focal_i(cfg_q.inv_focal),
    .coord_o    (x_coord),
    .sat_o      (x_sat)
  );

  dpbp_lane u_lane_y (
    .clk_i      (clk_i),
    .off_i      (front.off_y),
    .z_i        (front.z),
    .inv_focal_i(cfg_q.inv_focal),
    .coord_o    (y_coord),
    .sat_o      (y_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= front.valid;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    z2_q <= front.z;
    z3_q <= z2_q;
    z4_q <= z3_q;
  end

  assign out_valid_o = v4_q;
  assign result_o = '{point_x: x_coord, point_y: y_coord, point_z: z4_q,
                      clipped: x_sat || y_sat};

  a_no_word_without_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##4 !out_valid_o)
    else $error("result word without a start four cycles earlier");

  a_negative_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && in_i.depth_raw[15] |-> ##4 !out_valid_o)
    else $error("negative depth produced a word");

  a_valid_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start, 4))
    else $error("word does not line up with its start");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_o.clipped |->
      (result_o.point_x == 16'sh7fff || result_o.point_x == 16'sh8000 ||
       result_o.point_y == 16'sh7fff || result_o.point_y == 16'sh8000))
    else $error("clipped flag set without a saturated coordinate");

endmodule
